// ===== hw/rtl/mbe_pkg.sv =====
// Shared types, constants and helper functions for the escape-time pixel engine.
package mbe_pkg;

	localparam int IMAGE_WIDTH    = 800;
	localparam int IMAGE_HEIGHT   = 600;
	localparam int MAX_ITERATIONS = 800;

	localparam int PIX_W       = 10;
	localparam int ITER_OUT_W  = 10;
	localparam int COLOR_W     = 8;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 64;
	localparam int STEP_W      = 63;
	localparam int FRAC_BITS   = 58;
	localparam int ITER_W      = $clog2(MAX_ITERATIONS + 1);

	localparam int HALF_W   = IMAGE_WIDTH / 2;
	localparam int HALF_H   = IMAGE_HEIGHT / 2;
	localparam int HALF_MAX = (HALF_W > HALF_H) ? HALF_W : HALF_H;
	// Signed width of (pixel - half) for any pixel code and image size.
	localparam int DELTA_W  = $clog2(HALF_MAX + (1 << PIX_W)) + 1;
	localparam int PROD_W   = STEP_W + DELTA_W - 1;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef logic signed [63:0] q_t;

	localparam q_t Q_MAX          = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam q_t Q_MIN          = 64'sh8000_0000_0000_0000;
	localparam q_t Q_QUARTER      = 64'sh0100_0000_0000_0000;
	localparam q_t Q_NEG_QUARTER  = 64'shFF00_0000_0000_0000;
	localparam q_t Q_SIXTEENTH    = 64'sh0040_0000_0000_0000;
	localparam q_t Q_ONE          = 64'sh0400_0000_0000_0000;
	localparam q_t Q_FOUR         = 64'sh1000_0000_0000_0000;

	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_X   = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_Y   = 8'd3;

	localparam q_t           OFFSET_X_RST = 64'sd0;
	localparam q_t           OFFSET_Y_RST = 64'sd0;
	localparam logic [STEP_W-1:0] STEP_X_RST = 63'd2522015791327477;
	localparam logic [STEP_W-1:0] STEP_Y_RST = 63'd1921535841011411;

	typedef struct packed {
		q_t   cx;
		q_t   cy;
		logic in_set;
	} point_t;

	typedef struct packed {
		logic start;
		logic half_shift;
		q_t   a;
		q_t   b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		q_t   res;
	} mul_rsp_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MAPX,
		F_MAPY,
		F_MAPC,
		F_MUL,
		F_WAIT,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		FOP_CY2,
		FOP_XM2,
		FOP_LHS,
		FOP_RHS,
		FOP_BULB
	} front_op_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_CHECK,
		B_MUL,
		B_WAIT,
		B_ROM,
		B_OUT
	} back_state_t;

	typedef enum logic [1:0] {
		BOP_ZX2,
		BOP_ZY2,
		BOP_CROSS
	} back_op_t;

	typedef logic [3*COLOR_W-1:0] rom_t [0:MAX_ITERATIONS];

	localparam longint unsigned ROM_M  = 64'(MAX_ITERATIONS);
	localparam longint unsigned ROM_M4 = ROM_M * ROM_M * ROM_M * ROM_M;

	function automatic q_t sat_add(q_t a, q_t b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? Q_MIN : Q_MAX;
		return q_t'(s[63:0]);
	endfunction

	function automatic q_t sat_neg(q_t a);
		if (a == Q_MIN)
			return Q_MAX;
		return -a;
	endfunction

	function automatic logic [63:0] mag(q_t a);
		return a[63] ? 64'(-a) : 64'(a);
	endfunction

	// Colour palette: 9, 15 and 8.5 times the Bernstein-like polynomial, times 255.
	function automatic rom_t build_rom();
		rom_t t;
		longint unsigned i, u, r, g, b;
		for (int k = 0; k <= MAX_ITERATIONS; k++) begin
			i = 64'(k);
			u = ROM_M - i;
			r = 64'd2295 * u * i * i * i / ROM_M4;
			g = 64'd3825 * u * u * i * i / ROM_M4;
			b = 64'd4335 * u * u * u * i / (2 * ROM_M4);
			t[k] = {r[7:0], g[7:0], b[7:0]};
		end
		return t;
	endfunction

endpackage

// ===== hw/rtl/mbe_if.sv =====
// Handshake channel interfaces for pixels, results and register writes.
interface mbe_pixel_if;
	logic                       valid;
	logic                       ready;
	logic [mbe_pkg::PIX_W-1:0]  pixel_col;
	logic [mbe_pkg::PIX_W-1:0]  pixel_row;
	modport source (output valid, pixel_col, pixel_row, input ready);
	modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface mbe_result_if;
	logic                            valid;
	logic                            ready;
	logic [mbe_pkg::ITER_OUT_W-1:0]  iterations;
	logic [mbe_pkg::COLOR_W-1:0]     red;
	logic [mbe_pkg::COLOR_W-1:0]     green;
	logic [mbe_pkg::COLOR_W-1:0]     blue;
	modport source (output valid, iterations, red, green, blue, input ready);
	modport sink   (input valid, iterations, red, green, blue, output ready);
endinterface

interface mbe_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [mbe_pkg::CFG_INDEX_W-1:0]  index;
	logic [mbe_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mbe_mul.sv =====
// Sequential Q6.58 multiplier built from four 32x32 partial products.
module mbe_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  mbe_pkg::mul_req_t req,
	output mbe_pkg::mul_rsp_t rsp
);

	localparam logic [2:0] LAST_CNT = 3'd5;
	localparam int FB = mbe_pkg::FRAC_BITS;

	logic          busy_q;
	logic          done_q;
	logic [2:0]    cnt_q;
	logic [63:0]   x_q;
	logic [63:0]   y_q;
	logic          neg_q;
	logic          sh57_q;
	logic [63:0]   pp_q;
	logic [1:0]    pp_sh_q;
	logic [127:0]  acc_q;
	mbe_pkg::q_t   res_q;

	logic [31:0]   x_part;
	logic [31:0]   y_part;
	logic [127:0]  pp_ext;
	mbe_pkg::q_t   fin;
	logic          ovf;
	logic          rem;
	logic [63:0]   m;
	logic [64:0]   mi;

	assign x_part = cnt_q[1] ? x_q[63:32] : x_q[31:0];
	assign y_part = cnt_q[0] ? y_q[63:32] : y_q[31:0];

	always_comb begin
		unique case (pp_sh_q)
			2'd0:    pp_ext = {64'd0, pp_q};
			2'd1:    pp_ext = {32'd0, pp_q, 32'd0};
			2'd2:    pp_ext = {pp_q, 64'd0};
			default: pp_ext = '0;
		endcase
	end

	// Floor rounding of the signed product and saturation to 64 bits.
	always_comb begin
		if (sh57_q) begin
			ovf = |acc_q[127:FB+63];
			m   = acc_q[FB+62:FB-1];
			rem = |acc_q[FB-2:0];
		end else begin
			ovf = |acc_q[127:FB+64];
			m   = acc_q[FB+63:FB];
			rem = |acc_q[FB-1:0];
		end
		mi = {1'b0, m} + 65'(rem);
		if (ovf)
			fin = neg_q ? mbe_pkg::Q_MIN : mbe_pkg::Q_MAX;
		else if (!neg_q)
			fin = m[63] ? mbe_pkg::Q_MAX : mbe_pkg::q_t'(m);
		else if (mi[64] || mi[63])
			fin = mbe_pkg::Q_MIN;
		else
			fin = -mbe_pkg::q_t'(mi[63:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == LAST_CNT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			x_q    <= mbe_pkg::mag(req.a);
			y_q    <= mbe_pkg::mag(req.b);
			neg_q  <= req.a[63] ^ req.b[63];
			sh57_q <= req.half_shift;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (!cnt_q[2]) begin
				pp_q    <= x_part * y_part;
				pp_sh_q <= {cnt_q[1] & cnt_q[0], cnt_q[1] ^ cnt_q[0]};
			end
			if (cnt_q != 3'd0 && cnt_q <= 3'd4)
				acc_q <= acc_q + pp_ext;
			if (cnt_q == LAST_CNT)
				res_q <= fin;
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

// ===== hw/rtl/mbe_front.sv =====
// Front end: maps a pixel to c and runs the cardioid and bulb tests.
module mbe_front (
	input  logic                               clk,
	input  logic                               arst_n,
	mbe_pixel_if.sink                          pixel,
	input  mbe_pkg::q_t                        offset_x,
	input  mbe_pkg::q_t                        offset_y,
	input  logic [mbe_pkg::STEP_W-1:0]         step_x,
	input  logic [mbe_pkg::STEP_W-1:0]         step_y,
	output logic                               push_valid,
	input  logic                               push_ready,
	output mbe_pkg::point_t                    push_data
);

	localparam int DW = mbe_pkg::DELTA_W;
	localparam int PW = mbe_pkg::PROD_W;

	mbe_pkg::front_state_t  state_q, state_d;
	mbe_pkg::front_op_t     op_q, op_d;
	mbe_pkg::mul_req_t      mul_req;
	mbe_pkg::mul_rsp_t      mul_rsp;

	logic signed [DW-1:0]   dx_q;
	logic signed [DW-1:0]   dy_q;
	logic [PW-1:0]          prod_q;
	mbe_pkg::q_t            cx_q;
	mbe_pkg::q_t            cy_q;
	mbe_pkg::q_t            cy2_q;
	mbe_pkg::q_t            qv_q;
	mbe_pkg::q_t            lhs_q;
	logic                   card_q;
	logic                   bulb_q;

	logic [DW-2:0]          adx;
	logic [DW-2:0]          ady;
	mbe_pkg::q_t            xm;
	mbe_pkg::q_t            xp;

	function automatic mbe_pkg::q_t from_prod(logic neg, logic [PW-1:0] p);
		mbe_pkg::q_t v;
		v = mbe_pkg::q_t'({1'b0, p[mbe_pkg::STEP_W-1:0]});
		if (|p[PW-1:mbe_pkg::STEP_W])
			return neg ? mbe_pkg::Q_MIN : mbe_pkg::Q_MAX;
		return neg ? -v : v;
	endfunction

	assign adx = dx_q[DW-1] ? (DW-1)'(-dx_q) : dx_q[DW-2:0];
	assign ady = dy_q[DW-1] ? (DW-1)'(-dy_q) : dy_q[DW-2:0];
	assign xm  = mbe_pkg::sat_add(cx_q, mbe_pkg::Q_NEG_QUARTER);
	assign xp  = mbe_pkg::sat_add(cx_q, mbe_pkg::Q_ONE);

	mbe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbe_pkg::F_IDLE;
			op_q    <= mbe_pkg::FOP_CY2;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d            = state_q;
		op_d               = op_q;
		pixel.ready        = 1'b0;
		push_valid         = 1'b0;
		mul_req.start      = 1'b0;
		mul_req.half_shift = 1'b0;
		mul_req.a          = '0;
		mul_req.b          = '0;
		unique case (op_q)
			mbe_pkg::FOP_CY2: begin
				mul_req.a = cy_q;
				mul_req.b = cy_q;
			end
			mbe_pkg::FOP_XM2: begin
				mul_req.a = xm;
				mul_req.b = xm;
			end
			mbe_pkg::FOP_LHS: begin
				mul_req.a = qv_q;
				mul_req.b = mbe_pkg::sat_add(qv_q, xm);
			end
			mbe_pkg::FOP_RHS: begin
				mul_req.a = cy2_q;
				mul_req.b = mbe_pkg::Q_QUARTER;
			end
			mbe_pkg::FOP_BULB: begin
				mul_req.a = xp;
				mul_req.b = xp;
			end
			default: begin
				mul_req.a = '0;
				mul_req.b = '0;
			end
		endcase
		unique case (state_q)
			mbe_pkg::F_IDLE: begin
				pixel.ready = 1'b1;
				if (pixel.valid)
					state_d = mbe_pkg::F_MAPX;
			end
			mbe_pkg::F_MAPX: state_d = mbe_pkg::F_MAPY;
			mbe_pkg::F_MAPY: state_d = mbe_pkg::F_MAPC;
			mbe_pkg::F_MAPC: begin
				op_d    = mbe_pkg::FOP_CY2;
				state_d = mbe_pkg::F_MUL;
			end
			mbe_pkg::F_MUL: begin
				mul_req.start = 1'b1;
				state_d       = mbe_pkg::F_WAIT;
			end
			mbe_pkg::F_WAIT: begin
				if (mul_rsp.done) begin
					state_d = mbe_pkg::F_MUL;
					unique case (op_q)
						mbe_pkg::FOP_CY2:  op_d = mbe_pkg::FOP_XM2;
						mbe_pkg::FOP_XM2:  op_d = mbe_pkg::FOP_LHS;
						mbe_pkg::FOP_LHS:  op_d = mbe_pkg::FOP_RHS;
						mbe_pkg::FOP_RHS:  op_d = mbe_pkg::FOP_BULB;
						mbe_pkg::FOP_BULB: state_d = mbe_pkg::F_PUSH;
						default:           state_d = mbe_pkg::F_PUSH;
					endcase
				end
			end
			mbe_pkg::F_PUSH: begin
				push_valid = 1'b1;
				if (push_ready)
					state_d = mbe_pkg::F_IDLE;
			end
			default: state_d = mbe_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mbe_pkg::F_IDLE: begin
				if (pixel.valid) begin
					dx_q <= DW'(pixel.pixel_col) - DW'(mbe_pkg::HALF_W);
					dy_q <= DW'(pixel.pixel_row) - DW'(mbe_pkg::HALF_H);
				end
			end
			mbe_pkg::F_MAPX: prod_q <= adx * step_x;
			mbe_pkg::F_MAPY: begin
				cx_q   <= mbe_pkg::sat_add(from_prod(dx_q[DW-1], prod_q), offset_x);
				prod_q <= ady * step_y;
			end
			mbe_pkg::F_MAPC: begin
				cy_q <= mbe_pkg::sat_add(from_prod(dy_q[DW-1], prod_q), offset_y);
			end
			mbe_pkg::F_WAIT: begin
				if (mul_rsp.done) begin
					unique case (op_q)
						mbe_pkg::FOP_CY2:  cy2_q  <= mul_rsp.res;
						mbe_pkg::FOP_XM2:  qv_q   <= mbe_pkg::sat_add(mul_rsp.res, cy2_q);
						mbe_pkg::FOP_LHS:  lhs_q  <= mul_rsp.res;
						mbe_pkg::FOP_RHS:  card_q <= (lhs_q <= mul_rsp.res);
						mbe_pkg::FOP_BULB: begin
							bulb_q <= (mbe_pkg::sat_add(mul_rsp.res, cy2_q)
								<= mbe_pkg::Q_SIXTEENTH);
						end
						default: card_q <= card_q;
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	assign push_data.cx     = cx_q;
	assign push_data.cy     = cy_q;
	assign push_data.in_set = card_q | bulb_q;

endmodule

// ===== hw/rtl/mbe_fifo.sv =====
// Small queue of classified points between the front and back ends.
module mbe_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  mbe_pkg::point_t  push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output mbe_pkg::point_t  pop_data
);

	localparam int D  = mbe_pkg::FIFO_DEPTH;
	localparam int PW = mbe_pkg::FIFO_PTR_W;
	localparam int CW = mbe_pkg::FIFO_CNT_W;

	mbe_pkg::point_t  mem_q [D];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CW'(D));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [PW-1:0] next_ptr(logic [PW-1:0] p);
		return (p == PW'(D - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== hw/rtl/mbe_back.sv =====
// Back end: iterates z = z*z + c, looks up the colour and holds the result.
module mbe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  mbe_pkg::point_t  pop_data,
	mbe_result_if.source     result
);

	localparam int IW = mbe_pkg::ITER_W;
	localparam logic [IW-1:0] ITER_LIMIT = IW'(mbe_pkg::MAX_ITERATIONS);
	localparam mbe_pkg::rom_t COLOUR_ROM = mbe_pkg::build_rom();

	mbe_pkg::back_state_t  state_q, state_d;
	mbe_pkg::back_op_t     op_q, op_d;
	mbe_pkg::mul_req_t     mul_req;
	mbe_pkg::mul_rsp_t     mul_rsp;

	mbe_pkg::q_t           cx_q;
	mbe_pkg::q_t           cy_q;
	mbe_pkg::q_t           zx_q;
	mbe_pkg::q_t           zy_q;
	mbe_pkg::q_t           zx2_q;
	mbe_pkg::q_t           zy2_q;
	logic [IW-1:0]         n_q;
	logic [3*mbe_pkg::COLOR_W-1:0] rgb_q;

	logic                  out_valid_q;
	logic [IW-1:0]         out_iter_q;
	logic [3*mbe_pkg::COLOR_W-1:0] out_rgb_q;

	logic                  escaped;
	logic                  out_load;

	assign escaped  = (mbe_pkg::sat_add(zx2_q, mul_rsp.res) > mbe_pkg::Q_FOUR);
	assign out_load = (state_q == mbe_pkg::B_OUT) && (!out_valid_q || result.ready);

	mbe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mbe_pkg::B_IDLE;
			op_q        <= mbe_pkg::BOP_ZX2;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d            = state_q;
		op_d               = op_q;
		pop_ready          = 1'b0;
		mul_req.start      = 1'b0;
		mul_req.half_shift = (op_q == mbe_pkg::BOP_CROSS);
		mul_req.a          = (op_q == mbe_pkg::BOP_ZY2) ? zy_q : zx_q;
		mul_req.b          = (op_q == mbe_pkg::BOP_ZX2) ? zx_q : zy_q;
		unique case (state_q)
			mbe_pkg::B_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid)
					state_d = pop_data.in_set ? mbe_pkg::B_ROM : mbe_pkg::B_CHECK;
			end
			mbe_pkg::B_CHECK: begin
				op_d    = mbe_pkg::BOP_ZX2;
				state_d = (n_q == ITER_LIMIT) ? mbe_pkg::B_ROM : mbe_pkg::B_MUL;
			end
			mbe_pkg::B_MUL: begin
				mul_req.start = 1'b1;
				state_d       = mbe_pkg::B_WAIT;
			end
			mbe_pkg::B_WAIT: begin
				if (mul_rsp.done) begin
					unique case (op_q)
						mbe_pkg::BOP_ZX2: begin
							op_d    = mbe_pkg::BOP_ZY2;
							state_d = mbe_pkg::B_MUL;
						end
						mbe_pkg::BOP_ZY2: begin
							op_d    = mbe_pkg::BOP_CROSS;
							state_d = escaped ? mbe_pkg::B_ROM : mbe_pkg::B_MUL;
						end
						mbe_pkg::BOP_CROSS: state_d = mbe_pkg::B_CHECK;
						default:            state_d = mbe_pkg::B_CHECK;
					endcase
				end
			end
			mbe_pkg::B_ROM: state_d = mbe_pkg::B_OUT;
			mbe_pkg::B_OUT: begin
				if (out_load)
					state_d = mbe_pkg::B_IDLE;
			end
			default: state_d = mbe_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mbe_pkg::B_IDLE: begin
				if (pop_valid) begin
					cx_q <= pop_data.cx;
					cy_q <= pop_data.cy;
					zx_q <= '0;
					zy_q <= '0;
					n_q  <= pop_data.in_set ? ITER_LIMIT : '0;
				end
			end
			mbe_pkg::B_WAIT: begin
				if (mul_rsp.done) begin
					unique case (op_q)
						mbe_pkg::BOP_ZX2: zx2_q <= mul_rsp.res;
						mbe_pkg::BOP_ZY2: zy2_q <= mul_rsp.res;
						mbe_pkg::BOP_CROSS: begin
							zy_q <= mbe_pkg::sat_add(mul_rsp.res, cy_q);
							zx_q <= mbe_pkg::sat_add(mbe_pkg::sat_add(zx2_q,
								mbe_pkg::sat_neg(zy2_q)), cx_q);
							n_q  <= n_q + IW'(1);
						end
						default: n_q <= n_q;
					endcase
				end
			end
			mbe_pkg::B_ROM: rgb_q <= COLOUR_ROM[n_q];
			default: begin
			end
		endcase
		if (out_load) begin
			out_iter_q <= n_q;
			out_rgb_q  <= rgb_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.iterations = mbe_pkg::ITER_OUT_W'(out_iter_q);
	assign result.red        = out_rgb_q[3*mbe_pkg::COLOR_W-1:2*mbe_pkg::COLOR_W];
	assign result.green      = out_rgb_q[2*mbe_pkg::COLOR_W-1:mbe_pkg::COLOR_W];
	assign result.blue       = out_rgb_q[mbe_pkg::COLOR_W-1:0];

endmodule

// ===== hw/rtl/mandelbrot_pixel_escape_time.sv =====
// Top level of the escape-time pixel engine: register file, front end, queue, back end.
//
// Each pixel transfer names a column and row. The front end maps it to a point c in signed
// Q6.58 fixed point, using the view offsets and per-pixel steps held in the register file,
// and tests c against the main cardioid and the period-2 bulb, using five products through
// the front end's 32x32 partial-product multiplier. Classified points wait in a two-entry
// queue. The back end iterates z = z*z + c with its own multiplier, up to the limit of 800
// iterations, while points inside the cardioid or bulb skip the iteration and report the
// full count. The count and its palette colour sit in an output register, so the back end
// starts the next point while a result transfer is still pending. Register writes are
// always taken (ready is tied high) and must only be issued while the engine is idle.
// All arithmetic saturates, and pixels beyond the image size are mapped by the same
// formula.
module mandelbrot_pixel_escape_time (
	input  logic          clk,
	input  logic          arst_n,
	mbe_pixel_if.sink     pixel,
	mbe_result_if.source  result,
	mbe_cfg_if.sink       cfg
);

	mbe_pkg::q_t                   offset_x_q;
	mbe_pkg::q_t                   offset_y_q;
	logic [mbe_pkg::STEP_W-1:0]    step_x_q;
	logic [mbe_pkg::STEP_W-1:0]    step_y_q;

	logic                          q_push_valid;
	logic                          q_push_ready;
	mbe_pkg::point_t               q_push_data;
	logic                          q_pop_valid;
	logic                          q_pop_ready;
	mbe_pkg::point_t               q_pop_data;

	// The register file accepts a write in every cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= mbe_pkg::OFFSET_X_RST;
			offset_y_q <= mbe_pkg::OFFSET_Y_RST;
			step_x_q   <= mbe_pkg::STEP_X_RST;
			step_y_q   <= mbe_pkg::STEP_Y_RST;
		end else if (cfg.valid) begin
			// Writes to an index past the last register are dropped.
			unique case (cfg.index)
				mbe_pkg::REG_OFFSET_X: offset_x_q <= mbe_pkg::q_t'(cfg.data);
				mbe_pkg::REG_OFFSET_Y: offset_y_q <= mbe_pkg::q_t'(cfg.data);
				mbe_pkg::REG_STEP_X:   step_x_q   <= cfg.data[mbe_pkg::STEP_W-1:0];
				mbe_pkg::REG_STEP_Y:   step_y_q   <= cfg.data[mbe_pkg::STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: pixel mapping and the quick inside-the-set tests.
	mbe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.offset_x   (offset_x_q),
		.offset_y   (offset_y_q),
		.step_x     (step_x_q),
		.step_y     (step_y_q),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data)
	);

	// The queue lets the front end classify the next pixel during a long iteration run.
	mbe_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	// Back end: the escape iteration, palette lookup and output register.
	mbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (q_pop_valid),
		.pop_ready (q_pop_ready),
		.pop_data  (q_pop_data),
		.result    (result)
	);

endmodule

// ===== hw/rtl/mbe_checker.sv =====
// Port-level checks for the escape-time pixel engine, bound to the top level.
module mbe_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [mbe_pkg::ITER_OUT_W-1:0]    iterations,
	input logic [mbe_pkg::COLOR_W-1:0]       red,
	input logic [mbe_pkg::COLOR_W-1:0]       green,
	input logic [mbe_pkg::COLOR_W-1:0]       blue
);

	localparam logic [mbe_pkg::ITER_OUT_W-1:0] ITER_LIMIT =
		mbe_pkg::ITER_OUT_W'(mbe_pkg::MAX_ITERATIONS);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped before its transfer");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(iterations) && $stable(red)
			&& $stable(green) && $stable(blue))
		else $error("result payload changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> iterations <= ITER_LIMIT)
		else $error("iteration count above the limit");

	// The palette is black at both ends of the count range.
	a_black_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (iterations == '0 || iterations == ITER_LIMIT)
			|-> red == '0 && green == '0 && blue == '0)
		else $error("colour at zero or full count is not black");

endmodule

bind mandelbrot_pixel_escape_time mbe_checker u_mbe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.iterations (result.iterations),
	.red        (result.red),
	.green      (result.green),
	.blue       (result.blue)
);
